FILE: rtl/clsr_pkg.sv
// Package for the combined LCG / shuffle-table random number generator.
// Holds the generator constants, widths, codes and the step-unit request and response types.
// No dependencies.
`default_nettype none

package clsr_pkg;

  // Shuffle table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 8);

  // Field widths
  localparam int VAL_W  = 31;
  localparam int SEED_W = 31;
  localparam int K_W    = 16;

  // Generator constants (m = a*q + r)
  localparam longint MOD_A        = 64'd2147483563;
  localparam longint MOD_B        = 64'd2147483399;
  localparam longint MUL_A        = 64'd40014;
  localparam longint MUL_B        = 64'd40692;
  localparam longint QUO_A        = 64'd53668;
  localparam longint QUO_B        = 64'd52774;
  localparam longint REM_A        = 64'd12211;
  localparam longint REM_B        = 64'd3791;
  localparam longint SECOND_RESET = 64'd123456789;
  localparam longint MOD_A_LESS1  = MOD_A - 64'd1;

  // Reciprocals for the divisions by q (estimate is low by at most one)
  localparam longint RECIP_A = (64'd1 << 32) / QUO_A;
  localparam longint RECIP_B = (64'd1 << 32) / QUO_B;
  localparam int     RECIP_W = 17;

  // Slot divisor and its reciprocal
  localparam longint SLOT_DIV   = 64'd1 + MOD_A_LESS1 / TABLE_DEPTH;
  localparam longint SLOT_RECIP = (64'd1 << 32) / SLOT_DIV;
  localparam int     SLOT_PW    = 33 + IDX_W;

  // Request codes
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_sel_e;

  // Step unit request and response
  typedef struct packed {
    logic              start;
    gen_sel_e          sel;
    logic [VAL_W-1:0]  value;
  } step_req_t;

  typedef struct packed {
    logic              done;
    logic [VAL_W-1:0]  value;
  } step_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/clsr_if.sv
// Valid/ready channel interfaces for the generator: request and response.
// Depends on clsr_pkg for field widths.
`default_nettype none

interface clsr_req_if
  import clsr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

interface clsr_rsp_if
  import clsr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/clsr_step.sv
// Four-stage Schrage step unit: value * a mod m for either generator.
// Depends on clsr_pkg for constants and the step request/response types.
`default_nettype none

module clsr_step
  import clsr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire step_req_t req_i,
  output step_rsp_t      rsp_o
);

  logic [3:0]        vld_q;
  gen_sel_e          sel_q;
  logic [VAL_W-1:0]  s1_q;
  logic [K_W-1:0]    k0_q;
  logic [K_W-1:0]    k2_q;
  logic [K_W-1:0]    rem2_q;
  logic [31:0]       p1_q;
  logic [31:0]       p2_q;
  logic [VAL_W-1:0]  res_q;

  logic [RECIP_W-1:0] recip_in;
  logic [K_W-1:0]     q_c;
  logic [K_W-1:0]     a_c;
  logic [K_W-1:0]     r_c;
  logic [VAL_W:0]     m_c;

  logic [47:0]       prod0;
  logic [31:0]       kq;
  logic [31:0]       rem0;
  logic [K_W-1:0]    k2_d;
  logic [K_W-1:0]    rem2_d;
  logic signed [33:0] v;

  // Reciprocal for the first stage follows the incoming request
  always_comb begin
    unique case (req_i.sel)
      GEN_FIRST:  recip_in = RECIP_W'(RECIP_A);
      GEN_SECOND: recip_in = RECIP_W'(RECIP_B);
      default:    recip_in = RECIP_W'(RECIP_A);
    endcase
  end

  // Later stages use the latched generator choice
  always_comb begin
    unique case (sel_q)
      GEN_FIRST: begin
        q_c = K_W'(QUO_A);
        a_c = K_W'(MUL_A);
        r_c = K_W'(REM_A);
        m_c = (VAL_W+1)'(MOD_A);
      end
      GEN_SECOND: begin
        q_c = K_W'(QUO_B);
        a_c = K_W'(MUL_B);
        r_c = K_W'(REM_B);
        m_c = (VAL_W+1)'(MOD_B);
      end
      default: begin
        q_c = K_W'(QUO_A);
        a_c = K_W'(MUL_A);
        r_c = K_W'(REM_A);
        m_c = (VAL_W+1)'(MOD_A);
      end
    endcase
  end

  // Quotient estimate, then one correction step
  assign prod0 = 48'(req_i.value) * 48'(recip_in);
  assign kq    = 32'(k0_q) * 32'(q_c);
  assign rem0  = 32'(s1_q) - kq;

  always_comb begin
    if (rem0 >= 32'(q_c)) begin
      k2_d   = k0_q + K_W'(1);
      rem2_d = K_W'(rem0 - 32'(q_c));
    end else begin
      k2_d   = k0_q;
      rem2_d = K_W'(rem0);
    end
  end

  // a*(s mod q) - k*r, wrapped once into range
  always_comb begin
    v = $signed({2'b00, p1_q}) - $signed({2'b00, p2_q});
    if (v < 0) begin
      v = v + $signed(34'(m_c));
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sel_q <= GEN_FIRST;
    end else begin
      vld_q <= {vld_q[2:0], req_i.start};
      if (req_i.start) begin
        sel_q <= req_i.sel;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      s1_q <= req_i.value;
      k0_q <= prod0[47:32];
    end
    if (vld_q[0]) begin
      k2_q   <= k2_d;
      rem2_q <= rem2_d;
    end
    if (vld_q[1]) begin
      p1_q <= 32'(a_c) * 32'(rem2_q);
      p2_q <= 32'(k2_q) * 32'(r_c);
    end
    if (vld_q[2]) begin
      res_q <= v[VAL_W-1:0];
    end
  end

  assign rsp_o.done  = vld_q[3];
  assign rsp_o.value = res_q;

endmodule

`default_nettype wire

FILE: rtl/combined_lcg_shuffle_rng.sv
// Combined LCG random number generator with a Bays-Durham shuffle table.
// Draw: the step units run while the slot is computed and the table read; the result is
//   registered once the output is free. Ready only in idle: one request at a time.
// Reseed: 40 dependent steps on the first generator, then a draw. Reset sets the
//   generators to 1 and 123456789 and clears the per-entry valid bits of the table,
//   so no clearing pass is needed.
`default_nettype none

module combined_lcg_shuffle_rng
  import clsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  clsr_req_if.sink   in_req_i,
  clsr_rsp_if.source out_rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEED_WAIT,
    ST_DRAW,
    ST_SLOT,
    ST_READ,
    ST_WAIT,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [VAL_W-1:0]     first_gen_q;
  logic [VAL_W-1:0]     second_gen_q;
  logic [VAL_W-1:0]     shuffle_out_q;
  logic [CNT_W-1:0]     step_cnt_q;
  logic [IDX_W:0]       est_q;
  logic [IDX_W-1:0]     slot_q;
  logic [TABLE_DEPTH-1:0] tbl_vld_q;
  logic                 out_valid_q;
  logic [VAL_W-1:0]     out_value_q;

  // Shuffle table memory
  logic [VAL_W-1:0]     tbl_mem [TABLE_DEPTH];
  logic [VAL_W-1:0]     rd_data_q;
  logic                 rd_vld_q;

  step_req_t            req_a;
  step_req_t            req_b;
  step_rsp_t            rsp_a;
  step_rsp_t            rsp_b;

  logic                 in_fire;
  logic                 out_free;
  logic [VAL_W-1:0]     seed_fixed;
  logic [SLOT_PW-1:0]   slot_prod;
  logic [32:0]          slot_chk;
  logic [IDX_W:0]       slot_full;
  logic [IDX_W-1:0]     slot_d;
  logic [VAL_W-1:0]     tbl_word;
  logic signed [33:0]   diff;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic                 seed_store;

  assign in_fire  = in_req_i.valid && in_req_i.ready;
  assign out_free = !out_valid_q || out_rsp_o.ready;
  assign in_req_i.ready = (state_q == ST_IDLE);

  assign out_rsp_o.valid        = out_valid_q;
  assign out_rsp_o.random_value = out_value_q;

  // Seed of zero becomes one
  assign seed_fixed = (in_req_i.seed_value == '0) ? VAL_W'(1) : in_req_i.seed_value;

  // Step unit requests
  assign req_a.start = (state_q == ST_SEED) || (state_q == ST_DRAW);
  assign req_a.sel   = GEN_FIRST;
  assign req_a.value = first_gen_q;
  assign req_b.start = (state_q == ST_DRAW);
  assign req_b.sel   = GEN_SECOND;
  assign req_b.value = second_gen_q;

  clsr_step u_step_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_a),
    .rsp_o  (rsp_a)
  );

  clsr_step u_step_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_b),
    .rsp_o  (rsp_b)
  );

  // Slot = shuffle_out / SLOT_DIV: reciprocal estimate, then correct and saturate
  assign slot_prod = SLOT_PW'(shuffle_out_q) * SLOT_PW'(SLOT_RECIP);
  assign slot_chk  = 33'(shuffle_out_q) - 33'(est_q) * 33'(SLOT_DIV);

  always_comb begin
    if (slot_chk >= 33'(SLOT_DIV)) begin
      slot_full = est_q + (IDX_W+1)'(1);
    end else begin
      slot_full = est_q;
    end
    if (slot_full > (IDX_W+1)'(TABLE_DEPTH - 1)) begin
      slot_d = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      slot_d = slot_full[IDX_W-1:0];
    end
  end

  // New output: old slot content minus second generator, wrapped into range
  assign tbl_word = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    diff = $signed({3'b000, tbl_word}) - $signed({3'b000, rsp_b.value});
    if (diff < 1) begin
      diff = diff + $signed(34'(MOD_A_LESS1));
    end
  end

  // Table writes: reseed fill from the top slot down, or draw replacement
  assign seed_store = (state_q == ST_SEED_WAIT) && rsp_a.done &&
                      (step_cnt_q < CNT_W'(TABLE_DEPTH));
  assign wr_en   = seed_store || ((state_q == ST_FINISH) && out_free);
  assign wr_addr = (state_q == ST_FINISH) ? slot_q : step_cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= rsp_a.value;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= tbl_mem[slot_q];
    end
  end

  // Sequencer, generator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      first_gen_q   <= VAL_W'(1);
      second_gen_q  <= VAL_W'(SECOND_RESET);
      shuffle_out_q <= '0;
      step_cnt_q    <= '0;
      est_q         <= '0;
      slot_q        <= '0;
      tbl_vld_q     <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      out_value_q   <= '0;
    end else begin
      // Finish state reloads the output register itself
      if (out_valid_q && out_rsp_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        tbl_vld_q[wr_addr] <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req_i.func == FUNC_RESEED) begin
              first_gen_q  <= seed_fixed;
              second_gen_q <= seed_fixed;
              step_cnt_q   <= CNT_W'(TABLE_DEPTH + 7);
              state_q      <= ST_SEED;
            end else begin
              state_q <= ST_DRAW;
            end
          end
        end
        ST_SEED: begin
          state_q <= ST_SEED_WAIT;
        end
        ST_SEED_WAIT: begin
          if (rsp_a.done) begin
            first_gen_q <= rsp_a.value;
            if (step_cnt_q == '0) begin
              shuffle_out_q <= rsp_a.value;
              state_q       <= ST_DRAW;
            end else begin
              step_cnt_q <= step_cnt_q - CNT_W'(1);
              state_q    <= ST_SEED;
            end
          end
        end
        ST_DRAW: begin
          est_q   <= slot_prod[32 +: (IDX_W+1)];
          state_q <= ST_SLOT;
        end
        ST_SLOT: begin
          slot_q  <= slot_d;
          state_q <= ST_READ;
        end
        ST_READ: begin
          rd_vld_q <= tbl_vld_q[slot_q];
          state_q  <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp_a.done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            first_gen_q   <= rsp_a.value;
            second_gen_q  <= rsp_b.value;
            shuffle_out_q <= diff[VAL_W-1:0];
            out_value_q   <= diff[VAL_W-1:0];
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clsr_checker.sv
// Port-level checker for the generator, bound to the top level.
// Depends on clsr_pkg for the output range.
`default_nettype none

module clsr_checker
  import clsr_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [VAL_W-1:0] out_value_i
);

  logic [1:0] pend_q;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_value_i >= VAL_W'(1)) && (out_value_i <= VAL_W'(MOD_A_LESS1)))
    else $error("random value out of range");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("ready held after a request was taken");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result shown with no request pending");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("stalled result changed");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_req_i.valid),
  .in_ready_i  (in_req_i.ready),
  .out_valid_i (out_rsp_o.valid),
  .out_ready_i (out_rsp_o.ready),
  .out_value_i (out_rsp_o.random_value)
);

`default_nettype wire
